FILE: hw/rtl/mtt_pkg.sv
// Shared types and constants for the move-toward-target block.
`default_nettype none
package mtt_pkg;
	localparam int CoordW = 24;
	localparam int SpeedW = 16;
	localparam int MultW = 4;
	localparam int IdxW = 3;
	localparam int CfgDataW = 24;
	// Squares of 25-bit differences, summed.
	localparam int SumW = 50;
	localparam int RootW = 25;
	// Product of a 25-bit magnitude and a 16-bit speed.
	localparam int ProdW = 41;
	localparam int ThrW = 21;

	localparam logic [IdxW-1:0] REG_TARGET_X = 3'd0;
	localparam logic [IdxW-1:0] REG_TARGET_Y = 3'd1;
	localparam logic [IdxW-1:0] REG_STEP_SPEED = 3'd2;
	localparam logic [IdxW-1:0] REG_TOLERANCE = 3'd3;
	localparam logic [IdxW-1:0] REG_MARGIN_MULT = 3'd4;

	typedef struct packed {
		logic load;     // capture a new tick and compute differences
		logic sq_x;     // square dx into the sum
		logic sq_y;     // square dy into the sum
		logic root_init;
		logic root_step;
		logic div_init_x;
		logic div_init_y;
		logic div_step;
		logic fin_x;
		logic fin_y;
		logic snap;
		logic out_load;
	} mtt_cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic do_move;
	} mtt_stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/mtt_if.sv
// Valid/ready channel interfaces for ticks, results and configuration writes.
`default_nettype none
interface mtt_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] cur_x;
	logic signed [23:0] cur_y;
	logic rotation_settled;
	logic scale_settled;
	modport source (output valid, cur_x, cur_y, rotation_settled, scale_settled, input ready);
	modport sink (input valid, cur_x, cur_y, rotation_settled, scale_settled, output ready);
endinterface

interface mtt_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] new_x;
	logic signed [23:0] new_y;
	logic arrived;
	logic all_settled;
	modport source (output valid, new_x, new_y, arrived, all_settled, input ready);
	modport sink (input valid, new_x, new_y, arrived, all_settled, output ready);
endinterface

interface mtt_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mtt_datapath.sv
// Datapath: differences, squares, bit-serial root, restoring divide, saturation.
`default_nettype none
module mtt_datapath (
	input  wire logic clk,
	input  wire mtt_pkg::mtt_cmd_t cmd,
	output mtt_pkg::mtt_stat_t stat,
	input  wire logic signed [23:0] cur_x,
	input  wire logic signed [23:0] cur_y,
	input  wire logic signed [23:0] target_x,
	input  wire logic signed [23:0] target_y,
	input  wire logic [15:0] step_speed,
	input  wire logic [15:0] tolerance,
	input  wire logic [3:0] margin_mult,
	output logic signed [23:0] res_x,
	output logic signed [23:0] res_y
);
	import mtt_pkg::*;

	logic signed [CoordW-1:0] cx_q, cy_q;
	logic signed [CoordW:0] dx_q, dy_q;
	logic [SumW-1:0] sum_q;
	logic [SumW-1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [4:0] rcnt_q;
	logic [ThrW-1:0] thr_q;
	logic [ProdW-1:0] num_q;
	logic [ProdW-1:0] quo_q;
	logic [RootW:0] drem_q;
	logic [5:0] dcnt_q;
	logic signed [CoordW-1:0] nx_q, ny_q;

	logic [CoordW:0] mag_sel;
	logic [SumW-1:0] sq;
	logic [RootW+1:0] trial;
	logic [RootW-1:0] spd_eff;
	logic [RootW:0] dshift;
	logic signed [CoordW+1:0] moved;
	logic signed [CoordW:0] dsel;
	logic signed [CoordW-1:0] csel;
	logic signed [CoordW-1:0] sat;
	localparam logic signed [CoordW+1:0] CMax = (26'sd1 <<< (CoordW-1)) - 26'sd1;
	localparam logic signed [CoordW+1:0] CMin = -(26'sd1 <<< (CoordW-1));

	always_comb begin
		if (cmd.sq_y)
			mag_sel = dy_q[CoordW] ? 25'(-dy_q) : 25'(dy_q);
		else
			mag_sel = dx_q[CoordW] ? 25'(-dx_q) : 25'(dx_q);
		sq = SumW'(mag_sel) * SumW'(mag_sel);
		// Two remainder bits per step against the trial value 4*root+1.
		trial = {root_q, 2'b01};
		spd_eff = (RootW'(step_speed) <= root_q) ? RootW'(step_speed) : root_q;
		dshift = {drem_q[RootW-1:0], num_q[ProdW-1]};
		dsel = cmd.fin_y ? dy_q : dx_q;
		csel = cmd.fin_y ? cy_q : cx_q;
		moved = dsel[CoordW] ? 26'(csel) - 26'({1'b0, quo_q[CoordW-1:0]})
			: 26'(csel) + 26'({1'b0, quo_q[CoordW-1:0]});
		if (|quo_q[ProdW-1:CoordW])
			moved = dsel[CoordW] ? CMin - 26'sd1 : CMax + 26'sd1;
		if (moved > CMax)
			sat = CoordW'(CMax);
		else if (moved < CMin)
			sat = CoordW'(CMin);
		else
			sat = CoordW'(moved);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= cur_x;
			cy_q <= cur_y;
			dx_q <= 25'(target_x) - 25'(cur_x);
			dy_q <= 25'(target_y) - 25'(cur_y);
			thr_q <= ThrW'((17'(tolerance) + 17'(step_speed)) * 21'(margin_mult));
			sum_q <= '0;
		end
		if (cmd.sq_x || cmd.sq_y)
			sum_q <= sum_q + sq;
		if (cmd.root_init) begin
			rem_q <= '0;
			root_q <= '0;
			rcnt_q <= 5'd25;
		end
		if (cmd.root_step) begin
			// Bring down the next two bits of the radicand.
			if ({rem_q[SumW-3:0], sum_q[2*rcnt_q-1 -: 2]} >= SumW'(trial)) begin
				rem_q <= {rem_q[SumW-3:0], sum_q[2*rcnt_q-1 -: 2]} - SumW'(trial);
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SumW-3:0], sum_q[2*rcnt_q-1 -: 2]};
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
			rcnt_q <= rcnt_q - 5'd1;
		end
		if (cmd.div_init_x || cmd.div_init_y) begin
			num_q <= ProdW'(cmd.div_init_y ? (dy_q[CoordW] ? 25'(-dy_q) : 25'(dy_q))
				: (dx_q[CoordW] ? 25'(-dx_q) : 25'(dx_q))) * ProdW'(spd_eff);
			drem_q <= '0;
			quo_q <= '0;
			dcnt_q <= 6'(ProdW);
		end
		if (cmd.div_step) begin
			num_q <= {num_q[ProdW-2:0], 1'b0};
			if (dshift >= {1'b0, root_q}) begin
				drem_q <= dshift - {1'b0, root_q};
				quo_q <= {quo_q[ProdW-2:0], 1'b1};
			end else begin
				drem_q <= dshift;
				quo_q <= {quo_q[ProdW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 6'd1;
		end
		if (cmd.fin_x)
			nx_q <= sat;
		if (cmd.fin_y)
			ny_q <= sat;
		if (cmd.snap) begin
			nx_q <= target_x;
			ny_q <= target_y;
		end
	end

	assign stat.root_done = (rcnt_q == 5'd0);
	assign stat.div_done = (dcnt_q == 6'd1);
	assign stat.do_move = (root_q != '0) && (root_q >= RootW'(thr_q));
	assign res_x = nx_q;
	assign res_y = ny_q;
endmodule
`default_nettype wire

FILE: hw/rtl/mtt_ctrl.sv
// Controller state machine sequencing one tick through the datapath.
`default_nettype none
module mtt_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic done_flag,
	input  wire mtt_pkg::mtt_stat_t stat,
	output mtt_pkg::mtt_cmd_t cmd,
	output logic busy,
	output logic arrive
);
	import mtt_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_SQX  = 12'b000000000010,
		S_SQY  = 12'b000000000100,
		S_RINI = 12'b000000001000,
		S_ROOT = 12'b000000010000,
		S_DIVX = 12'b000000100000,
		S_RUNX = 12'b000001000000,
		S_DIVY = 12'b000010000000,
		S_RUNY = 12'b000100000000,
		S_SNAP = 12'b001000000000,
		S_OUT  = 12'b010000000000,
		S_FINY = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic arrive_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire && !done_flag) begin
					cmd.load = 1'b1;
					state_d = S_SQX;
				end
			end
			S_SQX: begin cmd.sq_x = 1'b1; state_d = S_SQY; end
			S_SQY: begin cmd.sq_y = 1'b1; state_d = S_RINI; end
			S_RINI: begin cmd.root_init = 1'b1; state_d = S_ROOT; end
			S_ROOT: begin
				if (stat.root_done)
					state_d = stat.do_move ? S_DIVX : S_SNAP;
				else
					cmd.root_step = 1'b1;
			end
			S_DIVX: begin cmd.div_init_x = 1'b1; state_d = S_RUNX; end
			S_RUNX: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = S_DIVY;
			end
			S_DIVY: begin cmd.fin_x = 1'b1; cmd.div_init_y = 1'b1; state_d = S_RUNY; end
			S_RUNY: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = S_FINY;
			end
			// The y quotient is complete only after the last divide step.
			S_FINY: begin cmd.fin_y = 1'b1; state_d = S_OUT; end
			S_SNAP: begin cmd.snap = 1'b1; state_d = S_OUT; end
			S_OUT: begin
				cmd.out_load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			arrive_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) arrive_q <= 1'b0;
			if (cmd.snap) arrive_q <= 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign arrive = arrive_q;
endmodule
`default_nettype wire

FILE: hw/rtl/move_toward_target_step_core.sv
// Top level of the constant-speed move-toward-target block.
// Channels: "tick" takes the current position and the settled flags of the
// other tweens; "result" gives the new position with arrived and all_settled;
// "cfg" writes target_x, target_y, step_speed, tolerance, margin_mult by index.
// A tick runs through squaring, a 25-step bit-serial square root and, for a
// move, two 41-step restoring divides, one per axis on the shared divider.
// One tick is in flight at a time; the next is taken only after the last
// result has been transferred out of the output register.
// After the tick that snaps onto the target, later ticks are taken and
// dropped with no result until a write to one of the five registers clears the arrival.
// Reset restores the register defaults and clears the arrival flag.
// When the receiver stalls, the result is held in the output register and
// no tick is taken until that result is transferred.
`default_nettype none
module move_toward_target_step_core (
	input wire logic clk,
	input wire logic arst_n,
	mtt_in_if.sink tick,
	mtt_out_if.source result,
	mtt_cfg_if.sink cfg
);
	import mtt_pkg::*;

	logic signed [CoordW-1:0] target_x_q, target_y_q;
	logic [SpeedW-1:0] step_speed_q, tolerance_q;
	logic [MultW-1:0] margin_mult_q;
	logic done_q;
	logic out_valid_q;
	logic signed [CoordW-1:0] out_x_q, out_y_q;
	logic out_arr_q, out_set_q, rot_q, scl_q;
	mtt_cmd_t cmd;
	mtt_stat_t stat;
	logic busy, arrive;
	logic signed [CoordW-1:0] res_x, res_y;
	logic in_fire, cfg_fire;

	assign tick.ready = !busy && !out_valid_q;
	assign cfg.ready = 1'b1;
	assign in_fire = tick.valid && tick.ready;
	assign cfg_fire = cfg.valid && cfg.ready;

	mtt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .done_flag(done_q),
		.stat(stat), .cmd(cmd), .busy(busy), .arrive(arrive)
	);

	mtt_datapath u_dp (
		.clk(clk), .cmd(cmd), .stat(stat), .cur_x(tick.cur_x), .cur_y(tick.cur_y),
		.target_x(target_x_q), .target_y(target_y_q), .step_speed(step_speed_q),
		.tolerance(tolerance_q), .margin_mult(margin_mult_q),
		.res_x(res_x), .res_y(res_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			step_speed_q <= 16'd256;
			tolerance_q <= '0;
			margin_mult_q <= 4'd1;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg.index)
					REG_TARGET_X: begin target_x_q <= cfg.data; done_q <= 1'b0; end
					REG_TARGET_Y: begin target_y_q <= cfg.data; done_q <= 1'b0; end
					REG_STEP_SPEED: begin step_speed_q <= cfg.data[15:0]; done_q <= 1'b0; end
					REG_TOLERANCE: begin tolerance_q <= cfg.data[15:0]; done_q <= 1'b0; end
					REG_MARGIN_MULT: begin margin_mult_q <= cfg.data[3:0]; done_q <= 1'b0; end
					default: ;
				endcase
			end
			if (cmd.snap) done_q <= 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rot_q <= tick.rotation_settled;
			scl_q <= tick.scale_settled;
		end
		if (cmd.out_load) begin
			out_x_q <= res_x;
			out_y_q <= res_y;
			out_arr_q <= arrive;
			out_set_q <= arrive && rot_q && scl_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.new_x = out_x_q;
	assign result.new_y = out_y_q;
	assign result.arrived = out_arr_q;
	assign result.all_settled = out_set_q;

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !tick.ready) else $error("tick taken while busy");
	a_snap_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |=> done_q) else $error("arrival flag not set");
	a_settled_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.all_settled |-> result.arrived)
		else $error("settled without arrival");
endmodule
`default_nettype wire

FILE: test/move_toward_target_step_core_tb.sv
// Self-checking testbench for the move-toward-target block: directed and random ticks.
`default_nettype none
module move_toward_target_step_core_tb;
	import mtt_pkg::*;

	localparam logic [IdxW-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mtt_in_if tick_ch();
	mtt_out_if res_ch();
	mtt_cfg_if cfg_ch();

	move_toward_target_step_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch.sink),
		.result(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	always #2 clk = ~clk;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic arrived;
		logic all_settled;
	} move_res_t;

	// Predictor state.
	logic signed [23:0] tgt_x, tgt_y;
	logic [15:0] spd_q, tol_q;
	logic [3:0] mult_q;
	bit reached;

	move_res_t pending_moves[$];
	int mismatches = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int arrivals_seen = 0;
	int cfg_writes = 0;
	int res_wait = 0;
	bit stall_enable = 1'b1;
	// Set while valid is still high after a transfer, so a following tick can go back to back.
	bit tick_held = 1'b0;

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.cur_x = '0;
		tick_ch.cur_y = '0;
		tick_ch.rotation_settled = 1'b0;
		tick_ch.scale_settled = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
	end

	function automatic logic [63:0] int_root(logic [63:0] n);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [23:0] step_axis(longint cur, longint d,
			longint unsigned s, longint unsigned span);
		longint unsigned m, q;
		longint v;
		m = (d < 0) ? -d : d;
		q = (m * s) / span;
		v = (d < 0) ? cur - longint'(q) : cur + longint'(q);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	function automatic void predict_move(logic signed [23:0] cx, logic signed [23:0] cy,
			logic rs, logic ss);
		longint dx, dy;
		longint unsigned ax, ay, sum, span, thr, s;
		move_res_t r;
		if (reached)
			return;
		dx = longint'(tgt_x) - longint'(cx);
		dy = longint'(tgt_y) - longint'(cy);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sum = ax * ax + ay * ay;
		span = int_root(sum);
		thr = (longint'(tol_q) + longint'(spd_q)) * longint'(mult_q);
		if (span != 0 && span >= thr) begin
			s = (spd_q <= span) ? spd_q : span;
			r.x = step_axis(cx, dx, s, span);
			r.y = step_axis(cy, dy, s, span);
			r.arrived = 1'b0;
			r.all_settled = 1'b0;
		end else begin
			r.x = tgt_x;
			r.y = tgt_y;
			r.arrived = 1'b1;
			r.all_settled = rs & ss;
			reached = 1'b1;
		end
		pending_moves.push_back(r);
	endfunction

	task automatic release_tick();
		if (tick_held) begin
			tick_ch.valid <= 1'b0;
			tick_held = 1'b0;
		end
	endtask

	task automatic send_tick(logic signed [23:0] cx, logic signed [23:0] cy,
			logic rs, logic ss);
		int gap;
		gap = stall_enable ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			release_tick();
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.cur_x <= cx;
		tick_ch.cur_y <= cy;
		tick_ch.rotation_settled <= rs;
		tick_ch.scale_settled <= ss;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		predict_move(cx, cy, rs, ss);
		ticks_sent++;
		tick_held = 1'b1;
	endtask

	// Waits until every expected result is back, then lets a dropped tick drain.
	task automatic drain();
		release_tick();
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [IdxW-1:0] idx, logic [23:0] val);
		release_tick();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
		// An idle gap keeps the next write from landing in the same time step.
		@(posedge clk);
		case (idx)
			REG_TARGET_X: tgt_x = val;
			REG_TARGET_Y: tgt_y = val;
			REG_STEP_SPEED: spd_q = val[15:0];
			REG_TOLERANCE: tol_q = val[15:0];
			REG_MARGIN_MULT: mult_q = val[3:0];
			default: return;
		endcase
		reached = 1'b0;
	endtask

	task automatic set_all(logic [23:0] tx, logic [23:0] ty, logic [15:0] sp,
			logic [15:0] tl, logic [3:0] mm);
		drain();
		write_reg(REG_TARGET_X, tx);
		write_reg(REG_TARGET_Y, ty);
		write_reg(REG_STEP_SPEED, {8'd0, sp});
		write_reg(REG_TOLERANCE, {8'd0, tl});
		write_reg(REG_MARGIN_MULT, {20'd0, mm});
	endtask

	// Result receiver: for each result it waits a drawn number of cycles before taking it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				move_res_t got, want;
				got = {res_ch.new_x, res_ch.new_y, res_ch.arrived, res_ch.all_settled};
				results_seen++;
				if (got.arrived)
					arrivals_seen++;
				if (pending_moves.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%0d y=%0d", got.x, got.y);
				end else begin
					want = pending_moves.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d a=%b s=%b got x=%0d y=%0d a=%b s=%b",
								want.x, want.y, want.arrived, want.all_settled,
								got.x, got.y, got.arrived, got.all_settled);
					end
				end
				res_wait = stall_enable ? int'($urandom_range(0, 13)) : 0;
			end else if (res_ch.valid && res_wait > 0) begin
				res_wait--;
			end
			res_ch.ready <= (res_wait == 0);
		end
	end

	task automatic test_defaults();
		send_tick(24'sd0, 24'sd0, 1'b1, 1'b1);
		send_tick(24'sd1000, 24'sd0, 1'b1, 1'b1);
		write_reg(REG_UNUSED, 24'h123456);
		send_tick(24'sd5, 24'sd5, 1'b1, 1'b1);
	endtask

	task automatic test_extremes();
		set_all(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'd0, 4'd1);
		send_tick(-24'sd8388608, -24'sd8388608, 1'b0, 1'b1);
		send_tick(24'sd8388607, -24'sd8388608, 1'b1, 1'b0);
		send_tick(24'sd8388607, 24'sd8388607, 1'b1, 1'b1);
		set_all(24'h800000, 24'h000000, 16'd0, 16'd0, 4'd0);
		send_tick(24'sd8388607, 24'sd8388607, 1'b0, 1'b0);
		send_tick(-24'sd8388608, 24'sd0, 1'b1, 1'b1);
		set_all(24'd100, 24'd100, 16'hFFFF, 16'hFFFF, 4'd0);
		send_tick(24'sd0, 24'sd0, 1'b1, 1'b1);
		send_tick(24'sd0, 24'sd0, 1'b1, 1'b1);
		set_all(24'd0, 24'd0, 16'd256, 16'd512, 4'd15);
		send_tick(24'sd100000, 24'sd0, 1'b1, 1'b1);
		send_tick(24'sd1000, 24'sd1000, 1'b0, 1'b1);
		set_all(24'd0, 24'd0, 16'd256, 16'd0, 4'd5);
		send_tick(-24'sd2000, 24'sd3000, 1'b1, 1'b1);
		send_tick(24'sd300, 24'sd0, 1'b1, 1'b1);
	endtask

	task automatic test_random();
		int n;
		logic signed [23:0] px, py;
		n = 0;
		while (n < 600) begin
			drain();
			case ($urandom_range(0, 3))
				0: set_all(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
					4'($urandom));
				1: set_all(24'($urandom), 24'($urandom), 16'($urandom_range(0, 4096)),
					16'($urandom_range(0, 512)), 4'($urandom_range(0, 8)));
				default: set_all(24'($urandom_range(0, 8000) - 4000),
					24'($urandom_range(0, 8000) - 4000), 16'($urandom_range(64, 1024)),
					16'($urandom_range(0, 256)), 4'($urandom_range(1, 5)));
			endcase
			stall_enable = ($urandom_range(0, 4) != 0);
			px = 24'($urandom);
			py = 24'($urandom);
			if ($urandom_range(0, 1)) begin
				px = tgt_x + $signed(24'($urandom_range(0, 16000)) - 24'sd8000);
				py = tgt_y + $signed(24'($urandom_range(0, 16000)) - 24'sd8000);
			end
			// Mostly follow the object along its path so arrival is reached.
			repeat ($urandom_range(4, 30)) begin
				if (pending_moves.size() == 0 && !reached && $urandom_range(0, 7) != 0)
					send_tick(px, py, 1'($urandom), 1'($urandom));
				else
					send_tick(24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
				n++;
				if (pending_moves.size() != 0) begin
					release_tick();
					while (pending_moves.size() != 0)
						@(posedge clk);
				end
				if (results_seen > 0) begin
					px = res_ch.new_x;
					py = res_ch.new_y;
				end
			end
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		tgt_x = 0;
		tgt_y = 0;
		spd_q = 16'd256;
		tol_q = 0;
		mult_q = 4'd1;
		reached = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extremes();
		test_random();
		drain();
		$display("ran %0d ticks, %0d results, %0d arrivals, %0d register writes",
			ticks_sent, results_seen, arrivals_seen, cfg_writes);
		if (mismatches == 0 && pending_moves.size() == 0)
			$display("move_toward_target_step_core_tb: done, clean");
		else
			$display("move_toward_target_step_core_tb: done, errors");
		$finish;
	end

	initial begin
		#8000000;
		$display("timeout with %0d results outstanding", pending_moves.size());
		$display("move_toward_target_step_core_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

FILE: move_toward_target_step_core.f
hw/rtl/mtt_pkg.sv
hw/rtl/mtt_if.sv
hw/rtl/mtt_datapath.sv
hw/rtl/mtt_ctrl.sv
hw/rtl/move_toward_target_step_core.sv
test/move_toward_target_step_core_tb.sv
